// ===== rtl/assert_macros.svh =====
// shared assertion macros for the matcher checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define KMP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("kmp check failed");

// next-cycle implication, held off during reset
`define KMP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("kmp check failed");

`endif

// ===== rtl/kmp_pkg.sv =====
`default_nettype none
package kmp_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int MAX_TEXT    = 65536;

  localparam int PAT_AW  = $clog2(MAX_PATTERN);
  localparam int CNT_W   = $clog2(MAX_PATTERN + 1);
  localparam int POS_W   = $clog2(MAX_TEXT);
  localparam int DIFF_W  = (POS_W + 1 > CNT_W) ? POS_W + 1 : CNT_W;

  localparam int MODE_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int START_W = 16;
  localparam int ERR_W   = 2;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_CLEAR  = 2'd0;
  localparam mode_t MODE_APPEND = 2'd1;
  localparam mode_t MODE_TEXT   = 2'd2;

  localparam int ERR_PAT = 0;
  localparam int ERR_TXT = 1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic clear;
    logic ovf;
    logic skip;
    logic txt_start;
    logic step;
    logic commit;
    logic app_write;
    logic emit;
  } kmp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic len_zero;
    logic len_full;
    logic reported;
    logic done;
    logic commit_emit;
    logic out_free;
  } kmp_sts_t;

  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/kmp_if.sv =====
`default_nettype none
interface kmp_in_if import kmp_pkg::*; ();
  logic              valid;
  logic              ready;
  mode_t             mode;
  logic [CHAR_W-1:0] char_in;
  logic              text_last;

  modport source (output valid, output mode, output char_in, output text_last, input ready);
  modport sink (input valid, input mode, input char_in, input text_last, output ready);
endinterface

interface kmp_out_if import kmp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [START_W-1:0] match_start;
  logic [ERR_W-1:0]   error_flags;

  modport source (output valid, output found, output match_start, output error_flags,
                  input ready);
  modport sink (input valid, input found, input match_start, input error_flags,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/kmp_datapath.sv =====
`default_nettype none
module kmp_datapath import kmp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire kmp_cmd_t           cmd_i,
  output kmp_sts_t                sts_o,
  input  wire mode_t              in_mode_i,
  input  wire logic [CHAR_W-1:0]  in_char_i,
  input  wire logic               in_last_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic                    out_found_o,
  output logic [START_W-1:0]      out_start_o,
  output logic [ERR_W-1:0]        out_err_o
);

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT - 1);

  // pattern bytes and failure links
  logic [CHAR_W-1:0] pat_mem  [MAX_PATTERN];
  logic [PAT_AW-1:0] link_mem [MAX_PATTERN];
  logic [CHAR_W-1:0] pat_rd_q;
  logic [PAT_AW-1:0] link_rd_q;
  logic [PAT_AW-1:0] rd_addr;
  logic [PAT_AW-1:0] link_wr;

  // block state
  logic [CNT_W-1:0] len_q, len_d;
  logic [CNT_W-1:0] mc_q, mc_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             rep_q, rep_d;
  logic [ERR_W-1:0] err_q, err_d;
  logic [CHAR_W-1:0] last_pat_q;
  logic [PAT_AW-1:0] last_link_q;

  // current word
  logic [CHAR_W-1:0] chr_q;
  logic [CHAR_W-1:0] key_q;
  logic [PAT_AW-1:0] k_q;
  logic              nok_q;
  logic              last_q;
  logic [POS_W-1:0]  item_pos_q, item_pos_d;

  // pending result
  logic               pend_found_q, pend_found_d;
  logic [START_W-1:0] pend_start_q, pend_start_d;
  logic [ERR_W-1:0]   pend_err_q, pend_err_d;

  logic               out_valid_q;
  logic               out_found_q;
  logic [START_W-1:0] out_start_q;
  logic [ERR_W-1:0]   out_err_q;

  logic [CHAR_W-1:0] in_fold;
  logic              in_txt;
  logic [PAT_AW-1:0] k_start;
  logic              eq;
  logic [CNT_W-1:0]  r;
  logic              hit;
  logic [DIFF_W-1:0] pos1;
  logic [DIFF_W-1:0] r_x;
  logic [DIFF_W-1:0] start_full;
  logic              end_sess;

  assign in_fold = fold_char(in_char_i);
  assign in_txt  = (in_mode_i == MODE_TEXT);

  // starting candidate: matched count for text, link of the last byte for append
  always_comb begin
    if (in_txt) begin
      k_start = (mc_q >= len_q) ? '0 : mc_q[PAT_AW-1:0];
    end else if (len_q < CNT_W'(2)) begin
      k_start = '0;
    end else begin
      k_start = last_link_q;
    end
  end

  assign rd_addr = cmd_i.step ? link_rd_q : k_start;

  assign eq  = (pat_rd_q == key_q);
  assign r   = (nok_q || !eq) ? '0 : CNT_W'(k_q) + CNT_W'(1);
  assign hit = (r == len_q);
  assign link_wr = PAT_AW'(r);

  assign pos1       = DIFF_W'(item_pos_q) + DIFF_W'(1);
  assign r_x        = DIFF_W'(r);
  assign start_full = (pos1 >= r_x) ? pos1 - r_x : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.app_write) begin
      pat_mem[len_q[PAT_AW-1:0]]  <= chr_q;
      link_mem[len_q[PAT_AW-1:0]] <= link_wr;
    end
    pat_rd_q  <= pat_mem[rd_addr];
    link_rd_q <= link_mem[rd_addr];
  end

  always_comb begin
    len_d        = len_q;
    mc_d         = mc_q;
    pos_d        = pos_q;
    rep_d        = rep_q;
    err_d        = err_q;
    item_pos_d   = item_pos_q;
    pend_found_d = pend_found_q;
    pend_start_d = pend_start_q;
    pend_err_d   = pend_err_q;
    end_sess     = 1'b0;

    if (cmd_i.clear) begin
      len_d    = '0;
      err_d    = '0;
      end_sess = 1'b1;
    end
    if (cmd_i.ovf) begin
      err_d[ERR_PAT] = 1'b1;
    end
    if (cmd_i.skip && in_last_i) begin
      end_sess = 1'b1;
    end
    if (cmd_i.txt_start) begin
      if (pos_q >= POS_MAX) begin
        item_pos_d     = POS_MAX;
        err_d[ERR_TXT] = 1'b1;
      end else begin
        item_pos_d = pos_q;
        pos_d      = pos_q + POS_W'(1);
      end
      // empty pattern matches at once
      if (len_q == '0) begin
        pend_found_d = 1'b1;
        pend_start_d = '0;
        pend_err_d   = err_d;
        if (in_last_i) begin
          end_sess = 1'b1;
        end else begin
          rep_d = 1'b1;
        end
      end
    end
    if (cmd_i.commit) begin
      mc_d = r;
      if (hit) begin
        pend_found_d = 1'b1;
        pend_start_d = START_W'(start_full);
        pend_err_d   = err_d;
        if (last_q) begin
          end_sess = 1'b1;
        end else begin
          rep_d = 1'b1;
        end
      end else if (last_q) begin
        pend_found_d = 1'b0;
        pend_start_d = '0;
        pend_err_d   = err_d;
        end_sess     = 1'b1;
      end
    end
    if (cmd_i.app_write) begin
      len_d = len_q + CNT_W'(1);
    end
    if (end_sess) begin
      mc_d           = '0;
      pos_d          = '0;
      rep_d          = 1'b0;
      err_d[ERR_TXT] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      mc_q        <= '0;
      pos_q       <= '0;
      rep_q       <= 1'b0;
      err_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q <= len_d;
      mc_q  <= mc_d;
      pos_q <= pos_d;
      rep_q <= rep_d;
      err_q <= err_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_pos_q   <= item_pos_d;
    pend_found_q <= pend_found_d;
    pend_start_q <= pend_start_d;
    pend_err_q   <= pend_err_d;
    if (cmd_i.accept) begin
      chr_q  <= in_fold;
      key_q  <= in_txt ? in_fold : last_pat_q;
      k_q    <= k_start;
      nok_q  <= !in_txt && (len_q < CNT_W'(2));
      last_q <= in_last_i;
    end
    if (cmd_i.step) begin
      k_q <= link_rd_q;
    end
    if (cmd_i.app_write) begin
      last_pat_q  <= chr_q;
      last_link_q <= link_wr;
    end
    if (cmd_i.emit) begin
      out_found_q <= pend_found_q;
      out_start_q <= pend_start_q;
      out_err_q   <= pend_err_q;
    end
  end

  assign sts_o.len_zero    = (len_q == '0);
  assign sts_o.len_full    = (len_q == CNT_W'(MAX_PATTERN));
  assign sts_o.reported    = rep_q;
  assign sts_o.done        = nok_q || eq || (k_q == '0);
  assign sts_o.commit_emit = hit || last_q;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_found_o = out_found_q;
  assign out_start_o = out_start_q;
  assign out_err_o   = out_err_q;

endmodule
`default_nettype wire

// ===== rtl/kmp_ctrl.sv =====
`default_nettype none
module kmp_ctrl import kmp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire mode_t    in_mode_i,
  output logic          in_ready_o,
  input  wire kmp_sts_t sts_i,
  output kmp_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       is_txt_q, is_txt_d;

  always_comb begin
    state_d    = state_q;
    is_txt_d   = is_txt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (in_mode_i)
            MODE_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            MODE_APPEND: begin
              if (sts_i.len_full) begin
                cmd_o.ovf = 1'b1;
              end else begin
                is_txt_d = 1'b0;
                state_d  = S_CMP;
              end
            end
            MODE_TEXT: begin
              if (sts_i.reported) begin
                cmd_o.skip = 1'b1;
              end else begin
                cmd_o.txt_start = 1'b1;
                is_txt_d        = 1'b1;
                state_d         = sts_i.len_zero ? S_EMIT : S_CMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CMP: begin
        // one fallback along the link chain per cycle
        if (!sts_i.done) begin
          cmd_o.step = 1'b1;
        end else if (is_txt_q) begin
          cmd_o.commit = 1'b1;
          state_d      = sts_i.commit_emit ? S_EMIT : S_IDLE;
        end else begin
          cmd_o.app_write = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      is_txt_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      is_txt_q <= is_txt_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/kmp_substring_matcher_unit.sv =====
`default_nettype none
// Case-insensitive Knuth-Morris-Pratt search over a byte stream. Each input word
// clears the pattern, appends one pattern byte (its failure link is built on
// arrival) or feeds one text byte; A-Z fold to lower case. A result word comes
// on the first match (found, start index) or at the last text byte without one
// (found low); later bytes of a matched text are swallowed. Clear, unused codes,
// dropped pattern bytes and bytes after a match are handled in the idle state.
// An append or a text byte is taken and then compared, with one more step per
// failure-link fallback, since each step is one registered read of the pattern
// and link memories followed by a compare; fallbacks average out to at most one
// per byte. A text byte against an empty pattern goes straight to the emit state.
// A result moves into the output register in the emit state; the register holds
// it while the next word is taken, and that move, and with it the input, waits
// for as long as an earlier result still sits unread there.
module kmp_substring_matcher_unit import kmp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  kmp_in_if.sink    in_i,
  kmp_out_if.source out_o
);

  kmp_cmd_t cmd;
  kmp_sts_t sts;

  kmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kmp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_mode_i   (in_i.mode),
    .in_char_i   (in_i.char_in),
    .in_last_i   (in_i.text_last),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_found_o (out_o.found),
    .out_start_o (out_o.match_start),
    .out_err_o   (out_o.error_flags)
  );

endmodule
`default_nettype wire

// ===== rtl/kmp_chk.sv =====
`default_nettype none
`include "assert_macros.svh"
module kmp_chk import kmp_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire mode_t              in_mode_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic               out_found_i,
  input wire logic [START_W-1:0] out_start_i,
  input wire logic [ERR_W-1:0]   out_err_i
);

  logic                       out_stall;
  logic [START_W+ERR_W:0]     out_word;
  logic                       clr_take;

  assign out_stall = out_valid_i && !out_ready_i;
  assign out_word  = {out_found_i, out_start_i, out_err_i};
  assign clr_take  = in_valid_i && in_ready_i && (in_mode_i == MODE_CLEAR);

  // stalled result word keeps its place and payload
  `KMP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i)
  `KMP_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(out_word))

  // a miss never carries a start index
  `KMP_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, out_valid_i && !out_found_i, out_start_i == '0)

  // a clear never holds up the next word
  `KMP_ASSERT_NXT(a_clear_quick, clk_i, rst_ni, clr_take, in_ready_i)

endmodule

bind kmp_substring_matcher_unit kmp_chk u_kmp_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_found_i (out_o.found),
  .out_start_i (out_o.match_start),
  .out_err_i   (out_o.error_flags)
);
`default_nettype wire
